### rtl/clse_pkg.sv
// ----------------------------------------------------------------------------
// clse_pkg
// Shared types and codes of the lock slot engine.
// ----------------------------------------------------------------------------
package clse_pkg;

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_ACQ  = 2'd1;
    localparam logic [1:0] PH_REL  = 2'd2;

    localparam logic [1:0] KIND_ACQ_CAS = 2'd0;
    localparam logic [1:0] KIND_REL_CAS = 2'd1;
    localparam logic [1:0] KIND_REL_WR  = 2'd2;

    localparam logic [1:0] ERR_NONE  = 2'd0;
    localparam logic [1:0] ERR_CPL   = 2'd1;
    localparam logic [1:0] ERR_SLOT  = 2'd2;
    localparam logic [1:0] ERR_RELCAS = 2'd3;

    localparam logic [1:0] REG_REL_CAS = 2'd0;
    localparam logic [1:0] REG_SHARD   = 2'd1;
    localparam logic [1:0] REG_NODES   = 2'd2;
    localparam logic [1:0] REG_TOTAL   = 2'd3;

    // classified word handed from front to back
    typedef struct packed {
        logic        is_cpl;
        logic        cpl_err;
        logic        slot_oor;
        logic [19:0] lock_id;
        logic [15:0] slot;
        logic [31:0] gen;
        logic [7:0]  phase;
        logic        old_zero;
        logic        old_one;
    } t_cmd;

    typedef struct packed {
        logic        post_valid;
        logic [1:0]  post_kind;
        logic [63:0] post_id;
        logic [7:0]  post_node;
        logic [19:0] post_lock;
        logic        compare_value;
        logic        swap_value;
        logic        retire_valid;
        logic [19:0] retired_lock;
        logic        all_done;
        logic [1:0]  error_code;
    } t_res;

endpackage

### rtl/clse_front.sv
// ----------------------------------------------------------------------------
// clse_front
// Takes input words, classifies them and holds them in a short queue.
// ----------------------------------------------------------------------------
module clse_front #(
    parameter int SLOTS = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    output logic            o_full,
    input  logic            i_op,
    input  logic [19:0]     i_lock_id,
    input  logic [63:0]     i_completion_id,
    input  logic [63:0]     i_old_value,
    input  logic            i_status_ok,
    output logic            o_cmd_valid,
    output clse_pkg::t_cmd  o_cmd,
    input  logic            i_cmd_take
);

    localparam int DEPTH = 2;

    clse_pkg::t_cmd r_q [DEPTH];
    logic           r_wp, r_rp;
    logic [1:0]     r_cnt;
    clse_pkg::t_cmd w_cmd;
    logic           w_in, w_out;

    always_comb begin
        w_cmd.is_cpl   = i_op;
        w_cmd.cpl_err  = !i_status_ok;
        w_cmd.slot_oor = ({16'd0, i_completion_id[31:16]} >= 32'(SLOTS));
        w_cmd.lock_id  = i_lock_id;
        w_cmd.slot     = i_completion_id[31:16];
        w_cmd.gen      = i_completion_id[63:32];
        w_cmd.phase    = i_completion_id[15:8];
        w_cmd.old_zero = (i_old_value == 64'd0);
        w_cmd.old_one  = (i_old_value == 64'd1);
    end

    assign o_full      = (r_cnt == 2'(DEPTH));
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];
    assign w_in        = i_push && !o_full;
    assign w_out       = i_cmd_take && o_cmd_valid;

    always_ff @(posedge i_clk) begin
        if (w_in) begin
            r_q[r_wp] <= w_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_in) r_wp <= !r_wp;
            if (w_out) r_rp <= !r_rp;
            r_cnt <= r_cnt + 2'(w_in) - 2'(w_out);
        end
    end

`ifndef NO_ASSERTIONS
    a_no_over: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 2'(DEPTH))
        else $error("front queue overflow");
    a_full_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_full && !w_out) |=> o_full)
        else $error("front queue lost an entry");
    a_take_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd0 && !w_in) |=> !o_cmd_valid)
        else $error("front queue invented an entry");
`endif

endmodule

### rtl/clse_back.sv
// ----------------------------------------------------------------------------
// clse_back
// Slot table sequencer: reads a slot, computes owner node, writes it back and
// emits at most one result word into a two-entry output queue.
// ----------------------------------------------------------------------------
module clse_back #(
    parameter int SLOTS = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cmd_valid,
    input  clse_pkg::t_cmd  i_cmd,
    output logic            o_cmd_take,
    input  logic            i_release_by_cas,
    input  logic            i_shard_by_lock,
    input  logic [8:0]      i_node_count,
    input  logic [31:0]     i_total_ops,
    output logic            o_empty,
    input  logic            i_pop,
    output clse_pkg::t_res  o_res
);

    localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int CW = $clog2(SLOTS + 1);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_EXEC = 3'd1;
    localparam logic [2:0] ST_MOD  = 3'd2;
    localparam logic [2:0] ST_EMIT = 3'd3;

    logic [SLOTS-1:0] r_busy;
    logic [1:0]       r_phase [SLOTS];
    logic [31:0]      r_gen   [SLOTS];
    logic [19:0]      r_lock  [SLOTS];
    logic [7:0]       r_node  [SLOTS];
    logic [31:0]      r_issued, r_retired;
    logic [CW-1:0]    r_busy_cnt;

    logic [2:0]       r_st;
    clse_pkg::t_cmd   r_cmd;
    logic [SW-1:0]    r_s;
    logic             r_sub;      // submit pending
    logic [19:0]      r_slock;
    logic [19:0]      r_mod;      // remainder being reduced
    logic [4:0]       r_mstep;
    clse_pkg::t_res   r_res;
    logic             r_have;     // result to queue
    clse_pkg::t_res   n_res;
    logic             n_have;

    // output queue
    clse_pkg::t_res   r_oq [2];
    logic             r_owp, r_orp;
    logic [1:0]       r_ocnt;

    // free slot search
    logic             w_free_ok;
    logic [SW-1:0]    w_free;
    always_comb begin
        w_free_ok = 1'b0;
        w_free    = '0;
        for (int k = SLOTS - 1; k >= 0; k--) begin
            if (!r_busy[k]) begin
                w_free_ok = 1'b1;
                w_free    = SW'(k);
            end
        end
    end

    logic [8:0] w_n;
    assign w_n = (i_node_count == 9'd0) ? 9'd1 :
                 (i_node_count > 9'd256) ? 9'd256 : i_node_count;

    assign o_cmd_take = (r_st == ST_IDLE) && i_cmd_valid && (r_ocnt == 2'd0);
    assign o_empty    = (r_ocnt == 2'd0);
    assign o_res      = r_oq[r_orp];

    logic w_done_now;
    assign w_done_now = (r_retired >= i_total_ops);

    logic [SW-1:0] w_cs;
    assign w_cs = r_cmd.slot[SW-1:0];

    // classification of the word in ST_EXEC
    logic w_start_ok, w_hit, w_acq, w_relfail, w_retire, w_resub;
    assign w_start_ok = !r_cmd.is_cpl && (32'(r_busy_cnt) < 32'(SLOTS))
                        && (r_issued < i_total_ops) && w_free_ok;
    assign w_hit      = r_cmd.is_cpl && !r_cmd.cpl_err && !r_cmd.slot_oor
                        && r_busy[w_cs] && (r_gen[w_cs] == r_cmd.gen)
                        && (r_cmd.phase == {6'd0, r_phase[w_cs]});
    assign w_acq      = w_hit && (r_phase[w_cs] == clse_pkg::PH_ACQ);
    assign w_relfail  = w_hit && !w_acq && i_release_by_cas && !r_cmd.old_one;
    assign w_retire   = w_hit && !w_acq && !w_relfail;
    assign w_resub    = (r_issued < i_total_ops);

    logic [7:0] w_node;
    assign w_node = i_shard_by_lock ? r_mod[7:0] : 8'd0;

    // shifted divisor for restoring remainder, one bit per cycle
    logic [31:0] w_dsh;
    assign w_dsh = {23'd0, w_n} << (5'd19 - r_mstep);

    always_comb begin
        n_res  = r_res;
        n_have = 1'b0;
        case (r_st)
            ST_EXEC: begin
                n_res          = '0;
                n_res.all_done = w_done_now;
                if (r_cmd.is_cpl && r_cmd.cpl_err) begin
                    n_res.error_code = clse_pkg::ERR_CPL;
                    n_have           = 1'b1;
                end else if (r_cmd.is_cpl && r_cmd.slot_oor) begin
                    n_res.error_code = clse_pkg::ERR_SLOT;
                    n_have           = 1'b1;
                end else if (w_acq) begin
                    n_res.post_valid = 1'b1;
                    n_res.post_node  = r_node[w_cs];
                    n_res.post_lock  = r_lock[w_cs];
                    if (r_cmd.old_zero) begin
                        n_res.post_id = {r_gen[w_cs], 16'(w_cs),
                            6'd0, clse_pkg::PH_REL, r_node[w_cs]};
                        if (i_release_by_cas) begin
                            n_res.post_kind     = clse_pkg::KIND_REL_CAS;
                            n_res.compare_value = 1'b1;
                        end else begin
                            n_res.post_kind = clse_pkg::KIND_REL_WR;
                        end
                    end else begin
                        n_res.post_kind  = clse_pkg::KIND_ACQ_CAS;
                        n_res.swap_value = 1'b1;
                        n_res.post_id    = {r_gen[w_cs], 16'(w_cs),
                            6'd0, clse_pkg::PH_ACQ, r_node[w_cs]};
                    end
                    n_have = 1'b1;
                end else if (w_relfail) begin
                    n_res.error_code = clse_pkg::ERR_RELCAS;
                    n_have           = 1'b1;
                end else if (w_retire) begin
                    n_res.retire_valid = 1'b1;
                    n_res.retired_lock = r_lock[w_cs];
                end
            end
            ST_EMIT: begin
                n_res.all_done = w_done_now;
                n_have         = 1'b1;
                if (r_sub) begin
                    n_res.post_valid    = 1'b1;
                    n_res.post_kind     = clse_pkg::KIND_ACQ_CAS;
                    n_res.post_id       = {r_gen[r_s] + 32'd1, 16'(r_s), 6'd0,
                        clse_pkg::PH_ACQ, w_node};
                    n_res.post_node     = w_node;
                    n_res.post_lock     = r_slock;
                    n_res.compare_value = 1'b0;
                    n_res.swap_value    = 1'b1;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st       <= ST_IDLE;
            r_busy     <= '0;
            r_issued   <= 32'd0;
            r_retired  <= 32'd0;
            r_busy_cnt <= '0;
            r_have     <= 1'b0;
            r_sub      <= 1'b0;
            for (int k = 0; k < SLOTS; k++) begin
                r_phase[k] <= clse_pkg::PH_IDLE;
                r_gen[k]   <= 32'd0;
            end
        end else begin
            r_have <= n_have;
            case (r_st)
                ST_IDLE: begin
                    if (o_cmd_take) begin
                        r_cmd <= i_cmd;
                        r_st  <= ST_EXEC;
                    end
                end
                ST_EXEC: begin
                    if (w_start_ok) begin
                        r_busy_cnt <= r_busy_cnt + CW'(1);
                        r_s     <= w_free;
                        r_slock <= r_cmd.lock_id;
                        r_sub   <= 1'b1;
                        r_mod   <= r_cmd.lock_id;
                        r_mstep <= 5'd0;
                        r_st    <= ST_MOD;
                    end else if (w_acq) begin
                        if (r_cmd.old_zero) r_phase[w_cs] <= clse_pkg::PH_REL;
                        r_st <= ST_IDLE;
                    end else if (w_retire) begin
                        // retire, maybe resubmit
                        r_s           <= w_cs;
                        r_busy[w_cs]  <= 1'b0;
                        r_phase[w_cs] <= clse_pkg::PH_IDLE;
                        if (r_retired != 32'hFFFF_FFFF) r_retired <= r_retired + 32'd1;
                        if (w_resub) begin
                            r_slock <= r_cmd.lock_id;
                            r_mod   <= r_cmd.lock_id;
                            r_mstep <= 5'd0;
                            r_sub   <= 1'b1;
                            r_st    <= ST_MOD;
                        end else begin
                            if (r_busy_cnt != '0) r_busy_cnt <= r_busy_cnt - CW'(1);
                            r_sub <= 1'b0;
                            r_st  <= ST_EMIT;
                        end
                    end else begin
                        r_st <= ST_IDLE;
                    end
                end
                ST_MOD: begin
                    // lock id mod node count, one quotient bit per cycle
                    if ({12'd0, r_mod} >= w_dsh) r_mod <= r_mod - w_dsh[19:0];
                    r_mstep <= r_mstep + 5'd1;
                    if (r_mstep == 5'd19) r_st <= ST_EMIT;
                end
                ST_EMIT: begin
                    r_st <= ST_IDLE;
                    if (r_sub) begin
                        r_busy[r_s]  <= 1'b1;
                        r_gen[r_s]   <= r_gen[r_s] + 32'd1;
                        r_lock[r_s]  <= r_slock;
                        r_node[r_s]  <= w_node;
                        r_phase[r_s] <= clse_pkg::PH_ACQ;
                        r_issued     <= r_issued + 32'd1;
                    end
                end
                default: r_st <= ST_IDLE;
            endcase
        end
    end

    logic w_opop;
    assign w_opop = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        r_res <= n_res;
        if (r_have) r_oq[r_owp] <= r_res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_owp  <= 1'b0;
            r_orp  <= 1'b0;
            r_ocnt <= 2'd0;
        end else begin
            if (r_have) r_owp <= !r_owp;
            if (w_opop) r_orp <= !r_orp;
            r_ocnt <= r_ocnt + 2'(r_have) - 2'(w_opop);
        end
    end

`ifndef NO_ASSERTIONS
    a_oq_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ocnt <= 2'd2)
        else $error("result queue overflow");
    a_busy_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_busy_cnt) <= 32'(SLOTS))
        else $error("busy count beyond slots");
    a_take_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd_take |=> (r_st == ST_EXEC))
        else $error("command taken but not executed");
    a_retired_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        1'b1 |=> (r_retired >= $past(r_retired)))
        else $error("retired count went back");
`endif

endmodule

### rtl/cas_lock_slot_engine_core.sv
// ----------------------------------------------------------------------------
// cas_lock_slot_engine_core
// Lock slot window driving remote compare-and-swap lock requests.
// ----------------------------------------------------------------------------
//  channel   handshake          words
//  input     i_push / o_full    op, lock id, completion id, old value, status
//  result    o_empty / i_pop    post request, retire report, done, error
//  config    APB write/read     release_by_cas, shard_by_lock, node_count, total_ops
//
// One word at a time in the slot sequencer: ST_EXEC alone for a word that does
// not submit, plus ST_EMIT for a retire with no resubmit, plus ST_MOD (20-step
// lock id remainder) for a submit; the result word is registered, then queued.
// Sync active-low reset clears slot state; no clearing pass.
// A new word is taken only while the result queue is empty; a stalled pop backs
// up into the two-entry front queue and then raises o_full.
// ----------------------------------------------------------------------------
module cas_lock_slot_engine_core #(
    parameter int SLOTS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    output logic        o_full,
    input  logic        i_op,
    input  logic [19:0] i_lock_id,
    input  logic [63:0] i_completion_id,
    input  logic [63:0] i_old_value,
    input  logic        i_status_ok,
    output logic        o_empty,
    input  logic        i_pop,
    output logic        o_post_valid,
    output logic [1:0]  o_post_kind,
    output logic [63:0] o_post_id,
    output logic [7:0]  o_post_node,
    output logic [19:0] o_post_lock,
    output logic        o_compare_value,
    output logic        o_swap_value,
    output logic        o_retire_valid,
    output logic [19:0] o_retired_lock,
    output logic        o_all_done,
    output logic [1:0]  o_error_code,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic        r_release_by_cas, r_shard_by_lock;
    logic [8:0]  r_node_count;
    logic [31:0] r_total_ops;
    logic        w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_release_by_cas <= 1'b1;
            r_shard_by_lock  <= 1'b0;
            r_node_count     <= 9'd1;
            r_total_ops      <= 32'd0;
        end else if (w_wr && paddr[1:0] == 2'd0) begin
            case (paddr[3:2])
                clse_pkg::REG_REL_CAS: r_release_by_cas <= pwdata[0];
                clse_pkg::REG_SHARD:   r_shard_by_lock  <= pwdata[0];
                clse_pkg::REG_NODES:   r_node_count     <= pwdata[8:0];
                clse_pkg::REG_TOTAL:   r_total_ops      <= pwdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            clse_pkg::REG_REL_CAS: prdata = {31'd0, r_release_by_cas};
            clse_pkg::REG_SHARD:   prdata = {31'd0, r_shard_by_lock};
            clse_pkg::REG_NODES:   prdata = {23'd0, r_node_count};
            clse_pkg::REG_TOTAL:   prdata = r_total_ops;
            default:               prdata = 32'd0;
        endcase
    end

    logic           w_cmd_valid, w_cmd_take;
    clse_pkg::t_cmd w_cmd;
    clse_pkg::t_res w_res;

    clse_front #(.SLOTS(SLOTS)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_push(i_push), .o_full(o_full),
        .i_op(i_op), .i_lock_id(i_lock_id), .i_completion_id(i_completion_id),
        .i_old_value(i_old_value), .i_status_ok(i_status_ok),
        .o_cmd_valid(w_cmd_valid), .o_cmd(w_cmd), .i_cmd_take(w_cmd_take)
    );

    clse_back #(.SLOTS(SLOTS)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cmd_valid(w_cmd_valid), .i_cmd(w_cmd), .o_cmd_take(w_cmd_take),
        .i_release_by_cas(r_release_by_cas), .i_shard_by_lock(r_shard_by_lock),
        .i_node_count(r_node_count), .i_total_ops(r_total_ops),
        .o_empty(o_empty), .i_pop(i_pop), .o_res(w_res)
    );

    assign o_post_valid    = w_res.post_valid;
    assign o_post_kind     = w_res.post_kind;
    assign o_post_id       = w_res.post_id;
    assign o_post_node     = w_res.post_node;
    assign o_post_lock     = w_res.post_lock;
    assign o_compare_value = w_res.compare_value;
    assign o_swap_value    = w_res.swap_value;
    assign o_retire_valid  = w_res.retire_valid;
    assign o_retired_lock  = w_res.retired_lock;
    assign o_all_done      = w_res.all_done;
    assign o_error_code    = w_res.error_code;

endmodule

### tb/sv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Drives cas_lock_slot_engine_core with start and completion words, most of
// them built from requests the engine has posted, and checks every result
// word against a cycle-free prediction of the slot window.
// ----------------------------------------------------------------------------
module testbench;

    localparam int SLOTS = 16;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int RANDOM_WORDS = 1100;

    logic        i_clk;
    logic        i_rst_n = 1'b0;
    logic        i_push = 1'b0;
    logic        o_full;
    logic        i_op = 1'b0;
    logic [19:0] i_lock_id = '0;
    logic [63:0] i_completion_id = '0;
    logic [63:0] i_old_value = '0;
    logic        i_status_ok = 1'b0;
    logic        o_empty;
    logic        i_pop = 1'b0;
    logic        o_post_valid;
    logic [1:0]  o_post_kind;
    logic [63:0] o_post_id;
    logic [7:0]  o_post_node;
    logic [19:0] o_post_lock;
    logic        o_compare_value;
    logic        o_swap_value;
    logic        o_retire_valid;
    logic [19:0] o_retired_lock;
    logic        o_all_done;
    logic [1:0]  o_error_code;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    int unsigned cycles = 0;

    cas_lock_slot_engine_core #(.SLOTS(SLOTS)) u_dut (.*);

    // prediction of the slot window plus the queue of expected result words
    class lock_scoreboard;
        bit          rel_cas = 1'b1;
        bit          shard = 1'b0;
        bit [8:0]    nodes = 9'd1;
        bit [31:0]   total = '0;
        bit          busy[SLOTS];
        bit [31:0]   gen[SLOTS];
        bit [1:0]    ph[SLOTS];
        bit [19:0]   lck[SLOTS];
        bit [7:0]    nd[SLOTS];
        bit [31:0]   issued = '0;
        bit [31:0]   retired = '0;
        int unsigned busy_n = 0;
        clse_pkg::t_res expected_q[$];
        bit [63:0]   live_ids[$];   // ids of posted requests still awaiting completion
        int unsigned errors = 0;
        int unsigned checked = 0;
        int unsigned retires = 0;
        int unsigned err_words = 0;

        function void set_reg(logic [1:0] idx, bit [31:0] v);
            case (idx)
                clse_pkg::REG_REL_CAS: rel_cas = v[0];
                clse_pkg::REG_SHARD:   shard = v[0];
                clse_pkg::REG_NODES:   nodes = v[8:0];
                clse_pkg::REG_TOTAL:   total = v;
                default: ;
            endcase
        endfunction

        function bit [63:0] make_id(int s, bit [1:0] p);
            return {gen[s], 16'(s), 8'(p), nd[s]};
        endfunction

        function void drop_id(bit [63:0] id);
            foreach (live_ids[i]) begin
                if (live_ids[i] == id) begin
                    live_ids.delete(i);
                    return;
                end
            end
        endfunction

        function void queue_acquire(int s, inout clse_pkg::t_res r);
            ph[s] = clse_pkg::PH_ACQ;
            r.post_valid = 1'b1;
            r.post_kind = clse_pkg::KIND_ACQ_CAS;
            r.post_id = make_id(s, clse_pkg::PH_ACQ);
            r.post_node = nd[s];
            r.post_lock = lck[s];
            r.compare_value = 1'b0;
            r.swap_value = 1'b1;
            live_ids.push_back(r.post_id);
        endfunction

        function void submit(int s, bit [19:0] lock, inout clse_pkg::t_res r);
            bit [8:0] n;
            n = (nodes == 0) ? 9'd1 : (nodes > 256) ? 9'd256 : nodes;
            busy[s] = 1'b1;
            gen[s] = gen[s] + 1;
            lck[s] = lock;
            nd[s] = shard ? 8'(lock % n) : 8'd0;
            issued = issued + 1;
            queue_acquire(s, r);
        endfunction

        // returns 1 when the word gives a result
        function bit note_input(bit op, bit [19:0] lock, bit [63:0] cid, bit [63:0] old,
                                bit ok);
            clse_pkg::t_res r;
            int             s;
            bit [7:0]       p;
            r = '0;
            r.all_done = (retired >= total);
            if (!op) begin
                if (busy_n >= SLOTS || issued >= total) return 1'b0;
                for (s = 0; s < SLOTS; s++) begin
                    if (!busy[s]) begin
                        busy_n++;
                        submit(s, lock, r);
                        expected_q.push_back(r);
                        return 1'b1;
                    end
                end
                return 1'b0;
            end
            if (!ok) begin
                r.error_code = clse_pkg::ERR_CPL;
                expected_q.push_back(r);
                return 1'b1;
            end
            if (cid[31:16] >= SLOTS) begin
                r.error_code = clse_pkg::ERR_SLOT;
                expected_q.push_back(r);
                return 1'b1;
            end
            s = int'(cid[31:16]);
            p = cid[15:8];
            if (!busy[s] || gen[s] != cid[63:32] || p != {6'd0, ph[s]}) return 1'b0;
            if (p == 8'(clse_pkg::PH_ACQ)) begin
                drop_id(cid);
                if (old == 0) begin
                    ph[s] = clse_pkg::PH_REL;
                    r.post_valid = 1'b1;
                    r.post_id = make_id(s, clse_pkg::PH_REL);
                    r.post_node = nd[s];
                    r.post_lock = lck[s];
                    r.post_kind = rel_cas ? clse_pkg::KIND_REL_CAS : clse_pkg::KIND_REL_WR;
                    r.compare_value = rel_cas;
                    live_ids.push_back(r.post_id);
                end else begin
                    queue_acquire(s, r);   // acquire lost, retry
                end
            end else begin
                if (rel_cas && old != 1) begin
                    r.error_code = clse_pkg::ERR_RELCAS;
                    expected_q.push_back(r);
                    return 1'b1;
                end
                drop_id(cid);
                r.retire_valid = 1'b1;
                r.retired_lock = lck[s];
                busy[s] = 1'b0;
                ph[s] = clse_pkg::PH_IDLE;
                if (retired != 32'hFFFF_FFFF) retired = retired + 1;
                if (busy_n > 0) busy_n--;
                if (issued < total) begin
                    busy_n++;
                    submit(s, lock, r);
                end
                r.all_done = (retired >= total);
            end
            expected_q.push_back(r);
            return 1'b1;
        endfunction

        function void field_check(string name, logic [63:0] e, logic [63:0] a);
            if (e !== a) begin
                $error("%s: expected %h, got %h", name, e, a);
                errors++;
            end
        endfunction

        function void check_result(clse_pkg::t_res got);
            clse_pkg::t_res e;
            if (expected_q.size() == 0) begin
                $error("result word with nothing expected");
                errors++;
                return;
            end
            e = expected_q.pop_front();
            checked++;
            if (e.retire_valid) retires++;
            if (e.error_code != clse_pkg::ERR_NONE) err_words++;
            field_check("post_valid", e.post_valid, got.post_valid);
            field_check("post_kind", e.post_kind, got.post_kind);
            field_check("post_id", e.post_id, got.post_id);
            field_check("post_node", e.post_node, got.post_node);
            field_check("post_lock", e.post_lock, got.post_lock);
            field_check("compare_value", e.compare_value, got.compare_value);
            field_check("swap_value", e.swap_value, got.swap_value);
            field_check("retire_valid", e.retire_valid, got.retire_valid);
            field_check("retired_lock", e.retired_lock, got.retired_lock);
            field_check("all_done", e.all_done, got.all_done);
            field_check("error_code", e.error_code, got.error_code);
        endfunction
    endclass

    lock_scoreboard sb = new();

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // result side: pop pattern steps through four modes, chosen by bits 10:9 of the cycle counter
    always @(negedge i_clk) begin
        case ((cycles >> 9) % 4)
            0: i_pop = 1'b1;
            1: i_pop = ($urandom_range(0, 1) == 0);
            2: i_pop = ($urandom_range(0, 7) == 0);
            default: i_pop = cycles[1];
        endcase
    end

    always @(posedge i_clk) begin
        clse_pkg::t_res got;
        cycles++;
        if (i_rst_n && i_pop && !o_empty) begin
            got.post_valid = o_post_valid;
            got.post_kind = o_post_kind;
            got.post_id = o_post_id;
            got.post_node = o_post_node;
            got.post_lock = o_post_lock;
            got.compare_value = o_compare_value;
            got.swap_value = o_swap_value;
            got.retire_valid = o_retire_valid;
            got.retired_lock = o_retired_lock;
            got.all_done = o_all_done;
            got.error_code = o_error_code;
            sb.check_result(got);
        end
        if (cycles > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic put_word(bit op, bit [19:0] lock, bit [63:0] cid, bit [63:0] old,
                            bit ok, output bit produced);
        @(negedge i_clk);
        i_push = 1'b1;
        i_op = op;
        i_lock_id = lock;
        i_completion_id = cid;
        i_old_value = old;
        i_status_ok = ok;
        do @(posedge i_clk); while (o_full);
        produced = sb.note_input(op, lock, cid, old, ok);
    endtask

    task automatic start(bit [19:0] lock);
        bit produced;
        put_word(1'b0, lock, {$urandom, $urandom}, {$urandom, $urandom}, 1'b1, produced);
    endtask

    task automatic complete(bit [63:0] cid, bit [63:0] old, bit ok = 1'b1);
        bit produced;
        put_word(1'b1, 20'($urandom), cid, old, ok, produced);
    endtask

    // wait out every expected word, then the longest sequencer pass
    task automatic settle();
        @(negedge i_clk);
        i_push = 1'b0;
        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
    endtask

    task automatic reg_write(logic [1:0] idx, bit [31:0] v);
        @(negedge i_clk);
        psel = 1'b1;
        penable = 1'b0;
        pwrite = 1'b1;
        paddr = {idx, 2'b00};
        pwdata = v;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.set_reg(idx, v);
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
    endtask

    task automatic configure(bit rel, bit shard, bit [8:0] nodes, bit [31:0] total);
        settle();
        reg_write(clse_pkg::REG_REL_CAS, {31'd0, rel});
        reg_write(clse_pkg::REG_SHARD, {31'd0, shard});
        reg_write(clse_pkg::REG_NODES, {23'd0, nodes});
        reg_write(clse_pkg::REG_TOTAL, total);
    endtask

    function automatic bit [63:0] live_for_slot(int s);
        foreach (sb.live_ids[i])
            if (sb.live_ids[i][31:16] == s) return sb.live_ids[i];
        return '1;
    endfunction

    task automatic random_word(output bit produced);
        bit [63:0] cid;
        bit [63:0] old;
        bit        op;
        bit        ok;
        int        k;
        int        n;
        cid = {$urandom, $urandom};
        old = {$urandom, $urandom};
        op = 1'b1;
        ok = ($urandom_range(0, 19) != 0);
        n = sb.live_ids.size();
        k = $urandom_range(0, 99);
        if (k < 18) begin
            op = 1'b0;
        end else if (k < 82 && n > 0) begin
            cid = sb.live_ids[$urandom_range(0, n - 1)];
            if (cid[15:8] == 8'(clse_pkg::PH_ACQ)) begin
                if ($urandom_range(0, 9) < 7) old = '0;
            end else if ($urandom_range(0, 9) < 8) begin
                old = 64'd1;
            end else if ($urandom_range(0, 1) == 0) begin
                old = '0;
            end
        end else if (k < 90 && n > 0) begin
            // stale: wrong generation, unused phase code or wrong phase
            cid = sb.live_ids[$urandom_range(0, n - 1)];
            case ($urandom_range(0, 2))
                0: cid[63:32] = cid[63:32] + 32'($urandom_range(1, 3));
                1: cid[15:8] = 8'($urandom_range(3, 255));
                default: cid[15:8] = (cid[15:8] == 8'(clse_pkg::PH_ACQ)) ?
                                     8'(clse_pkg::PH_REL) : 8'(clse_pkg::PH_ACQ);
            endcase
        end else if (k < 94) begin
            cid[31:16] = 16'($urandom_range(SLOTS, 16'hFFFF));
        end
        put_word(op, 20'($urandom), cid, old, ok, produced);
    endtask

    initial begin
        bit        produced;
        bit [63:0] id;
        int        counted;
        int        phase_words;
        int        burst;
        int        sel;
        bit        paused;

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: reset settings first, total_ops 0 so starts have no room
        start(20'h00000);
        complete({$urandom, $urandom}, '0, 1'b0);
        complete({32'd0, 16'd16, 8'(clse_pkg::PH_ACQ), 8'd0}, '0);
        complete({32'hFFFF_FFFF, 16'hFFFF, 8'hFF, 8'hFF}, '1);
        complete({32'd5, 16'd0, 8'(clse_pkg::PH_ACQ), 8'd0}, '0);

        configure(1'b1, 1'b1, 9'd5, 32'd3);
        start(20'hFFFFF);
        start(20'h00000);
        start(20'd12345);
        start(20'd7);   // issue limit reached
        complete(live_for_slot(0), '1);        // acquire lost, retry
        complete(live_for_slot(0), '0);        // acquire won, release CAS
        complete(live_for_slot(0), '0);        // release CAS failed
        complete(live_for_slot(0), 64'd1);     // retire
        id = live_for_slot(1);
        id[15:8] = 8'd3;
        complete(id, '0);                      // unused phase code

        configure(1'b0, 1'b1, 9'd300, 32'd3);
        complete(live_for_slot(1), '0);        // release by write
        complete(live_for_slot(1), {$urandom, $urandom});
        complete(live_for_slot(2), '0);
        complete(live_for_slot(2), 64'd5);     // last retire, all done

        counted = 0;
        sel = 0;
        paused = 1'b0;
        while (counted < RANDOM_WORDS) begin
            case (sel % 7)
                0: configure(1'b1, 1'b1, 9'd256, sb.issued + 60);
                1: configure(1'b0, 1'b1, 9'd1, sb.issued + 60);
                2: configure(1'b1, 1'b0, 9'd2, sb.issued + 40);
                3: configure(1'b0, 1'b1, 9'd511, 32'hFFFF_FFFF);
                4: configure(1'b1, 1'b1, 9'd0, sb.issued + 60);
                5: configure(1'b1, 1'b1, 9'd7, sb.issued);
                default: configure(1'b0, 1'b0, 9'd255, sb.issued + 80);
            endcase
            sel++;
            phase_words = 0;
            burst = $urandom_range(1, 12);
            while (phase_words < 170 && counted < RANDOM_WORDS) begin
                random_word(produced);
                if (produced) phase_words++;
                counted++;
                if (!paused && counted == RANDOM_WORDS / 2) begin
                    paused = 1'b1;
                    settle();
                end
                burst--;
                if (burst == 0) begin
                    burst = $urandom_range(1, 12);
                    if ($urandom_range(0, 3) != 0) begin
                        @(negedge i_clk);
                        i_push = 1'b0;
                        repeat ($urandom_range(0, 10)) @(negedge i_clk);
                    end
                end
            end
        end

        settle();
        $display("checked %0d result words: %0d retires, %0d error reports",
                 sb.checked, sb.retires, sb.err_words);
        $display("%0d acquires issued over %0d register settings", sb.issued, sel + 2);
        if (sb.errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
